/* rtl/core/rbsi_pkg.sv */
// Shared package for the ray/box slab intersect block.
// Holds parameter defaults, item kind codes and the multiplier control struct.
// No dependencies.
package rbsi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // item kind codes
   localparam logic KIND_RAY = 1'b0;
   localparam logic KIND_BOX = 1'b1;

   // per-stage load enables for the pipelined multiplier
   typedef struct packed {
      logic pp_load;
      logic sum_load;
   } mul_ctrl_type;

endpackage

/* rtl/core/rbsi_slab_diff.sv */
// One axis of the first pipeline stage: near/far plane pick and saturated distance.
// Depends on nothing but its ports.
module rbsi_slab_diff #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [COORD_WIDTH-1:0] corner_lo,
   input  logic signed [COORD_WIDTH-1:0] corner_hi,
   input  logic signed [COORD_WIDTH-1:0] origin,
   input  logic signed [COORD_WIDTH-1:0] inv_dir,
   output logic signed [COORD_WIDTH-1:0] near_diff,
   output logic signed [COORD_WIDTH-1:0] far_diff,
   output logic signed [COORD_WIDTH-1:0] inv_dir_out
);

   localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic signed [COORD_WIDTH-1:0] near_plane;
   logic signed [COORD_WIDTH-1:0] far_plane;
   logic        [COORD_WIDTH:0]   near_wide;
   logic        [COORD_WIDTH:0]   far_wide;
   logic signed [COORD_WIDTH-1:0] near_diff_in, near_diff_ff;
   logic signed [COORD_WIDTH-1:0] far_diff_in, far_diff_ff;
   logic signed [COORD_WIDTH-1:0] inv_dir_ff;

   // negative inverse direction swaps the planes; zero counts as positive
   assign near_plane = inv_dir[COORD_WIDTH-1] ? corner_hi : corner_lo;
   assign far_plane  = inv_dir[COORD_WIDTH-1] ? corner_lo : corner_hi;

   assign near_wide = {near_plane[COORD_WIDTH-1], near_plane} - {origin[COORD_WIDTH-1], origin};
   assign far_wide  = {far_plane[COORD_WIDTH-1], far_plane} - {origin[COORD_WIDTH-1], origin};

   // clamp when the extra sign bit disagrees
   always_comb begin
      near_diff_in = near_wide[COORD_WIDTH-1:0];
      if (near_wide[COORD_WIDTH] != near_wide[COORD_WIDTH-1]) begin
         near_diff_in = near_wide[COORD_WIDTH] ? SAT_MIN : SAT_MAX;
      end
      far_diff_in = far_wide[COORD_WIDTH-1:0];
      if (far_wide[COORD_WIDTH] != far_wide[COORD_WIDTH-1]) begin
         far_diff_in = far_wide[COORD_WIDTH] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         near_diff_ff <= near_diff_in;
         far_diff_ff  <= far_diff_in;
         inv_dir_ff   <= inv_dir;
      end
   end

   assign near_diff   = near_diff_ff;
   assign far_diff    = far_diff_ff;
   assign inv_dir_out = inv_dir_ff;

endmodule

/* rtl/core/rbsi_fx_mul.sv */
// Two-stage signed fixed-point multiplier: split partial products, then sum,
// shift by the fraction width and saturate. Uses rbsi_pkg::mul_ctrl_type.
module rbsi_fx_mul #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  rbsi_pkg::mul_ctrl_type        ctrl,
   input  logic signed [COORD_WIDTH-1:0] op_a,
   input  logic signed [COORD_WIDTH-1:0] op_b,
   output logic signed [COORD_WIDTH-1:0] product
);

   localparam int LH  = COORD_WIDTH / 2;
   localparam int HH  = COORD_WIDTH - LH;
   localparam int OW  = HH + 1;
   localparam int PPW = 2 * OW;
   localparam int PW  = 2 * COORD_WIDTH;
   localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic signed [OW-1:0]  a_lo, a_hi, b_lo, b_hi;
   logic signed [PPW-1:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic signed [PPW-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic signed [PW-1:0]  ext_ll, ext_lh, ext_hl, ext_hh;
   logic signed [PW-1:0]  full_sum;
   logic signed [PW-1:0]  shifted;
   logic signed [COORD_WIDTH-1:0] product_in, product_ff;

   // low halves are unsigned, high halves carry the sign
   assign a_lo = {{(OW-LH){1'b0}}, op_a[LH-1:0]};
   assign b_lo = {{(OW-LH){1'b0}}, op_b[LH-1:0]};
   assign a_hi = {op_a[COORD_WIDTH-1], op_a[COORD_WIDTH-1:LH]};
   assign b_hi = {op_b[COORD_WIDTH-1], op_b[COORD_WIDTH-1:LH]};

   assign pp_ll_in = a_lo * b_lo;
   assign pp_lh_in = a_lo * b_hi;
   assign pp_hl_in = a_hi * b_lo;
   assign pp_hh_in = a_hi * b_hi;

   always_ff @(posedge clock) begin
      if (ctrl.pp_load) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
      end
   end

   assign ext_ll = {{(PW-PPW){pp_ll_ff[PPW-1]}}, pp_ll_ff};
   assign ext_lh = {{(PW-PPW){pp_lh_ff[PPW-1]}}, pp_lh_ff};
   assign ext_hl = {{(PW-PPW){pp_hl_ff[PPW-1]}}, pp_hl_ff};
   assign ext_hh = {{(PW-PPW){pp_hh_ff[PPW-1]}}, pp_hh_ff};

   assign full_sum = (ext_hh <<< (2 * LH)) + ((ext_lh + ext_hl) <<< LH) + ext_ll;
   assign shifted  = full_sum >>> FRAC_BITS;

   // saturate unless every bit above the result's sign matches it
   always_comb begin
      product_in = shifted[COORD_WIDTH-1:0];
      if (shifted[PW-1:COORD_WIDTH-1] != {(PW-COORD_WIDTH+1){1'b0}} &&
          shifted[PW-1:COORD_WIDTH-1] != {(PW-COORD_WIDTH+1){1'b1}}) begin
         product_in = shifted[PW-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* rtl/core/rbsi_narrow.sv */
// Interval narrowing stage: raise the entry to the largest near distance and
// lower the exit to the smallest far distance. Depends on nothing but its ports.
module rbsi_narrow #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [COORD_WIDTH-1:0] t_start,
   input  logic signed [COORD_WIDTH-1:0] t_end,
   input  logic signed [COORD_WIDTH-1:0] t_near [3],
   input  logic signed [COORD_WIDTH-1:0] t_far  [3],
   output logic signed [COORD_WIDTH-1:0] t_lo,
   output logic signed [COORD_WIDTH-1:0] t_hi
);

   logic signed [COORD_WIDTH-1:0] lo_a, lo_b, hi_a, hi_b;
   logic signed [COORD_WIDTH-1:0] t_lo_in, t_lo_ff;
   logic signed [COORD_WIDTH-1:0] t_hi_in, t_hi_ff;

   // two-level compare tree on each side
   assign lo_a    = (t_near[0] > t_start)   ? t_near[0] : t_start;
   assign lo_b    = (t_near[2] > t_near[1]) ? t_near[2] : t_near[1];
   assign t_lo_in = (lo_b > lo_a) ? lo_b : lo_a;

   assign hi_a    = (t_far[0] < t_end)    ? t_far[0] : t_end;
   assign hi_b    = (t_far[2] < t_far[1]) ? t_far[2] : t_far[1];
   assign t_hi_in = (hi_b < hi_a) ? hi_b : hi_a;

   always_ff @(posedge clock) begin
      if (load) begin
         t_lo_ff <= t_lo_in;
         t_hi_ff <= t_hi_in;
      end
   end

   assign t_lo = t_lo_ff;
   assign t_hi = t_hi_ff;

endmodule

/* rtl/core/ray_box_slab_intersect.sv */
// Top level of the ray/box slab intersect block: ray registers, pipeline
// valid/ready control and the output stage. Uses rbsi_pkg, rbsi_slab_diff,
// rbsi_fx_mul and rbsi_narrow.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   req     | in        | req_valid/req_stall  | kind, vec_a_*, vec_b_*, interval_*
//   rsp     | out       | rsp_valid/rsp_stall  | hit, t_enter, t_exit
//
// A box item passes through five register stages in order: plane difference, two
// multiplier stages, narrowing and the output register. One box item enters every
// cycle unless req_stall holds it back.
// A ray item loads the ray registers and makes no result;
// boxes already in flight keep the ray they were accepted with.
// Reset (synchronous) clears the ray to zero and empties the pipeline.
// A stalled result holds; upstream stages keep advancing into empty slots,
// so an item is accepted while a result waits as long as a bubble is left.
module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic signed [COORD_WIDTH-1:0] req_vec_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_vec_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_vec_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_vec_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_vec_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_vec_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_interval_lo,
   input  logic signed [COORD_WIDTH-1:0] req_interval_hi,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_t_enter,
   output logic signed [COORD_WIDTH-1:0] rsp_t_exit
);

   // ------------------------------------------------------------------
   // Input handshake and ray registers
   // ------------------------------------------------------------------
   logic req_accept;
   logic ray_load;
   logic box_accept;

   logic signed [COORD_WIDTH-1:0] vec_a [3];
   logic signed [COORD_WIDTH-1:0] vec_b [3];

   logic signed [COORD_WIDTH-1:0] ray_origin_ff  [3];
   logic signed [COORD_WIDTH-1:0] ray_inv_dir_ff [3];
   logic signed [COORD_WIDTH-1:0] ray_t_start_ff, ray_t_end_ff;

   // stage valids and per-stage ready (stage may load)
   logic s1_valid_in, s1_valid_ff;
   logic s2_valid_in, s2_valid_ff;
   logic s3_valid_in, s3_valid_ff;
   logic s4_valid_in, s4_valid_ff;
   logic s5_valid_in, s5_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

   assign vec_a[0] = req_vec_a_x;
   assign vec_a[1] = req_vec_a_y;
   assign vec_a[2] = req_vec_a_z;
   assign vec_b[0] = req_vec_b_x;
   assign vec_b[1] = req_vec_b_y;
   assign vec_b[2] = req_vec_b_z;

   // a stage loads when it is empty or its content moves on
   assign s5_ready = !s5_valid_ff || !rsp_stall;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign ray_load   = req_accept && (req_kind == rbsi_pkg::KIND_RAY);
   assign box_accept = req_accept && (req_kind == rbsi_pkg::KIND_BOX);

   // load the ray; reset gives the all-zero ray
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ray_origin_ff[i]  <= '0;
            ray_inv_dir_ff[i] <= '0;
         end
         ray_t_start_ff <= '0;
         ray_t_end_ff   <= '0;
      end else if (ray_load) begin
         for (int i = 0; i < 3; i++) begin
            ray_origin_ff[i]  <= vec_a[i];
            ray_inv_dir_ff[i] <= vec_b[i];
         end
         ray_t_start_ff <= req_interval_lo;
         ray_t_end_ff   <= req_interval_hi;
      end
   end

   // ------------------------------------------------------------------
   // Valid bits: each advances when its stage loads
   // ------------------------------------------------------------------
   assign s1_valid_in = s1_ready ? box_accept  : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
   assign s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: plane pick and saturated plane - origin, per axis
   // ------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] near_diff [3];
   logic signed [COORD_WIDTH-1:0] far_diff  [3];
   logic signed [COORD_WIDTH-1:0] s1_inv_dir [3];
   logic signed [COORD_WIDTH-1:0] t_near [3];
   logic signed [COORD_WIDTH-1:0] t_far  [3];

   rbsi_pkg::mul_ctrl_type mul_ctrl;

   assign mul_ctrl.pp_load  = s2_ready;
   assign mul_ctrl.sum_load = s3_ready;

   for (genvar ax = 0; ax < 3; ax++) begin : g_axis
      rbsi_slab_diff #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_diff (
         .clock       (clock),
         .load        (s1_ready),
         .corner_lo   (vec_a[ax]),
         .corner_hi   (vec_b[ax]),
         .origin      (ray_origin_ff[ax]),
         .inv_dir     (ray_inv_dir_ff[ax]),
         .near_diff   (near_diff[ax]),
         .far_diff    (far_diff[ax]),
         .inv_dir_out (s1_inv_dir[ax])
      );

      // stages 2 and 3: partial products, then sum, shift and clamp
      rbsi_fx_mul #(
         .COORD_WIDTH(COORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_mul_near (
         .clock   (clock),
         .ctrl    (mul_ctrl),
         .op_a    (near_diff[ax]),
         .op_b    (s1_inv_dir[ax]),
         .product (t_near[ax])
      );

      rbsi_fx_mul #(
         .COORD_WIDTH(COORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_mul_far (
         .clock   (clock),
         .ctrl    (mul_ctrl),
         .op_a    (far_diff[ax]),
         .op_b    (s1_inv_dir[ax]),
         .product (t_far[ax])
      );
   end

   // carry the ray interval alongside the box through stages 1 to 3
   logic signed [COORD_WIDTH-1:0] s1_t_start_ff, s1_t_end_ff;
   logic signed [COORD_WIDTH-1:0] s2_t_start_ff, s2_t_end_ff;
   logic signed [COORD_WIDTH-1:0] s3_t_start_ff, s3_t_end_ff;

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_t_start_ff <= ray_t_start_ff;
         s1_t_end_ff   <= ray_t_end_ff;
      end
      if (s2_ready) begin
         s2_t_start_ff <= s1_t_start_ff;
         s2_t_end_ff   <= s1_t_end_ff;
      end
      if (s3_ready) begin
         s3_t_start_ff <= s2_t_start_ff;
         s3_t_end_ff   <= s2_t_end_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: narrow the interval over all three slabs
   // ------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] s4_t_lo, s4_t_hi;

   rbsi_narrow #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_narrow (
      .clock   (clock),
      .load    (s4_ready),
      .t_start (s3_t_start_ff),
      .t_end   (s3_t_end_ff),
      .t_near  (t_near),
      .t_far   (t_far),
      .t_lo    (s4_t_lo),
      .t_hi    (s4_t_hi)
   );

   // ------------------------------------------------------------------
   // Stage 5: hit decision and output register; hold while stalled
   // ------------------------------------------------------------------
   logic                          rsp_hit_ff;
   logic signed [COORD_WIDTH-1:0] rsp_t_enter_ff, rsp_t_exit_ff;

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         rsp_hit_ff     <= (s4_t_lo <= s4_t_hi);
         rsp_t_enter_ff <= s4_t_lo;
         rsp_t_exit_ff  <= s4_t_hi;
      end
   end

   assign rsp_valid   = s5_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_t_enter = rsp_t_enter_ff;
   assign rsp_t_exit  = rsp_t_exit_ff;

endmodule

/* rtl/core/rbsi_checker.sv */
// Port-level checks for ray_box_slab_intersect, attached by bind below.
// Depends on rbsi_pkg and the top level's ports.
module rbsi_checker #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_kind,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_hit,
   input logic signed [COORD_WIDTH-1:0] rsp_t_enter,
   input logic signed [COORD_WIDTH-1:0] rsp_t_exit
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) &&
         $stable(rsp_t_enter) && $stable(rsp_t_exit))
      else $error("stalled result changed");

   // hit agrees with the delivered interval
   a_hit_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_t_enter <= rsp_t_exit)))
      else $error("hit flag disagrees with interval");

   // with no output stall after acceptance, a box result comes out of the output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == rbsi_pkg::KIND_BOX)
         ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("box result missing after pipeline depth");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ray_box_slab_intersect rbsi_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_rbsi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_kind    (req_kind),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_hit     (rsp_hit),
   .rsp_t_enter (rsp_t_enter),
   .rsp_t_exit  (rsp_t_exit)
);
